/* rtl/vcpc_pkg.sv */
// Shared constants and the sideband type for the vertical capsule pair contact core.
// No dependencies; every other file in rtl refers to this package by scoped names.
package vcpc_pkg;

    // Epsilon 1e-6 on the Q32.32 grid.
    localparam logic [61:0] EPS_Q32 = 62'd4295;
    // A segment of length 2h is degenerate when (2h)^2 <= 4295, that is h <= 32.
    localparam logic [29:0] DEG_HALF_MAX = 30'd32;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [46:0] HALF_LSB = 47'd32768;

    localparam int RAD_W = 62;
    localparam int ROOT_W = 31;
    localparam int SQRT_STAGES = 31;
    localparam int Q_W = 17;
    localparam int DIV_STAGES = 17;
    localparam int NUM_W = 49;
    localparam int LANES = 3;

    typedef struct packed {
        logic               ok;
        logic               near;
        logic [31:0]        tag_a;
        logic [31:0]        tag_b;
        logic signed [31:0] ax;
        logic signed [31:0] az;
        logic signed [33:0] ca;
        logic [29:0]        ra;
        logic [30:0]        rs;
        logic               sx;
        logic               sy;
        logic               sz;
        logic [30:0]        mx;
        logic [30:0]        my;
        logic [30:0]        mz;
    } t_side;

endpackage

/* rtl/vcpc_front.sv */
// Front end: closest points on the two vertical axes, delta, squared distance and early reject.
// Four register stages. Depends on vcpc_pkg.
module vcpc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [31:0]                i_tag_first,
    input  logic [31:0]                i_tag_second,
    input  logic signed [31:0]         i_first_x,
    input  logic signed [31:0]         i_first_y,
    input  logic signed [31:0]         i_first_z,
    input  logic [29:0]                i_first_radius,
    input  logic [29:0]                i_first_half_len,
    input  logic signed [31:0]         i_second_x,
    input  logic signed [31:0]         i_second_y,
    input  logic signed [31:0]         i_second_z,
    input  logic [29:0]                i_second_radius,
    input  logic [29:0]                i_second_half_len,
    output logic                       o_valid,
    output vcpc_pkg::t_side            o_side,
    output logic [vcpc_pkg::RAD_W-1:0] o_rad
);

    function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
                                                  input logic signed [33:0] lo,
                                                  input logic signed [33:0] hi);
        logic signed [33:0] res;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic signed [33:0] a0, a1, b0, b1, n_ca, n_cb;
    logic               deg_a, deg_b;

    logic               r1_valid;
    logic [31:0]        r1_tag_a, r1_tag_b;
    logic signed [31:0] r1_ax, r1_az;
    logic [29:0]        r1_ra;
    logic [30:0]        r1_rs;
    logic signed [33:0] r1_ca, r1_cb;
    logic signed [32:0] r1_dx, r1_dz;

    logic signed [34:0] dy;
    logic [32:0]        mag_x, mag_z;
    logic [34:0]        mag_y;
    vcpc_pkg::t_side    n_side2;

    logic               r2_valid;
    vcpc_pkg::t_side    r2_side;

    logic               r3_valid;
    vcpc_pkg::t_side    r3_side;
    logic [61:0]        r3_sqx, r3_sqy, r3_sqz, r3_rs2;

    logic [63:0]        dsq;
    vcpc_pkg::t_side    n_side4;
    logic               r4_valid;
    vcpc_pkg::t_side    r4_side;
    logic [61:0]        r4_rad;

    always_comb begin
        a0 = 34'(i_first_y) - 34'(i_first_half_len);
        a1 = 34'(i_first_y) + 34'(i_first_half_len);
        b0 = 34'(i_second_y) - 34'(i_second_half_len);
        b1 = 34'(i_second_y) + 34'(i_second_half_len);
        deg_a = i_first_half_len <= vcpc_pkg::DEG_HALF_MAX;
        deg_b = i_second_half_len <= vcpc_pkg::DEG_HALF_MAX;
        priority if (deg_a && deg_b) begin
            n_ca = a0;
            n_cb = b0;
        end else if (deg_a) begin
            n_ca = a0;
            n_cb = clamp34(a0, b0, b1);
        end else if (deg_b) begin
            n_ca = clamp34(b0, a0, a1);
            n_cb = b0;
        end else if (a0 < b0) begin
            n_ca = clamp34(b0, a0, a1);
            n_cb = b0;
        end else if (a0 > b1) begin
            n_ca = a0;
            n_cb = b1;
        end else begin
            n_ca = a0;
            n_cb = a0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_tag_a <= i_tag_first;
        r1_tag_b <= i_tag_second;
        r1_ax    <= i_first_x;
        r1_az    <= i_first_z;
        r1_ra    <= i_first_radius;
        r1_rs    <= 31'(i_first_radius) + 31'(i_second_radius);
        r1_ca    <= n_ca;
        r1_cb    <= n_cb;
        r1_dx    <= 33'(i_second_x) - 33'(i_first_x);
        r1_dz    <= 33'(i_second_z) - 33'(i_first_z);
    end

    always_comb begin
        dy    = 35'(r1_cb) - 35'(r1_ca);
        mag_x = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
        mag_y = dy[34] ? 35'(-dy) : 35'(dy);
        mag_z = r1_dz[32] ? 33'(-r1_dz) : 33'(r1_dz);
        n_side2.ok    = (mag_x < 33'(r1_rs)) && (mag_y < 35'(r1_rs)) && (mag_z < 33'(r1_rs));
        n_side2.near  = 1'b0;
        n_side2.tag_a = r1_tag_a;
        n_side2.tag_b = r1_tag_b;
        n_side2.ax    = r1_ax;
        n_side2.az    = r1_az;
        n_side2.ca    = r1_ca;
        n_side2.ra    = r1_ra;
        n_side2.rs    = r1_rs;
        n_side2.sx    = r1_dx[32];
        n_side2.sy    = dy[34];
        n_side2.sz    = r1_dz[32];
        n_side2.mx    = mag_x[30:0];
        n_side2.my    = mag_y[30:0];
        n_side2.mz    = mag_z[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
        r2_side <= n_side2;
        r3_side <= r2_side;
        r3_sqx  <= 62'(r2_side.mx) * 62'(r2_side.mx);
        r3_sqy  <= 62'(r2_side.my) * 62'(r2_side.my);
        r3_sqz  <= 62'(r2_side.mz) * 62'(r2_side.mz);
        r3_rs2  <= 62'(r2_side.rs) * 62'(r2_side.rs);
    end

    assign dsq = 64'(r3_sqx) + 64'(r3_sqy) + 64'(r3_sqz);

    always_comb begin
        n_side4      = r3_side;
        n_side4.ok   = r3_side.ok && (dsq < 64'(r3_rs2));
        n_side4.near = dsq <= 64'(vcpc_pkg::EPS_Q32);
    end

    always_ff @(posedge i_clk) begin
        r4_side <= n_side4;
        r4_rad  <= (dsq <= 64'(vcpc_pkg::EPS_Q32)) ? vcpc_pkg::EPS_Q32 : dsq[61:0];
    end

    assign o_valid = r4_valid;
    assign o_side  = r4_side;
    assign o_rad   = r4_rad;

endmodule

/* rtl/vcpc_sqrt.sv */
// Pipelined floor integer square root, one result bit per register stage.
// Carries the item sideband alongside. Depends on vcpc_pkg.
module vcpc_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  vcpc_pkg::t_side             i_side,
    input  logic [vcpc_pkg::RAD_W-1:0]  i_rad,
    output logic                        o_valid,
    output vcpc_pkg::t_side             o_side,
    output logic [vcpc_pkg::ROOT_W-1:0] o_root
);

    localparam int N = vcpc_pkg::SQRT_STAGES;
    localparam int W = vcpc_pkg::RAD_W;

    logic            r_valid [0:N-1];
    vcpc_pkg::t_side r_side  [0:N-1];
    logic [W-1:0]    r_v     [0:N-1];
    logic [W-1:0]    r_r     [0:N-1];

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [W-1:0] BITV = W'(1) << (2 * (N - 1 - i));
        logic            in_valid;
        vcpc_pkg::t_side in_side;
        logic [W-1:0]    in_v, in_r, trial;

        if (i == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_side  = i_side;
            assign in_v     = i_rad;
            assign in_r     = '0;
        end else begin : g_next
            assign in_valid = r_valid[i-1];
            assign in_side  = r_side[i-1];
            assign in_v     = r_v[i-1];
            assign in_r     = r_r[i-1];
        end

        assign trial = in_r + BITV;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else begin
                r_valid[i] <= in_valid;
            end
            r_side[i] <= in_side;
            if (in_v >= trial) begin
                r_v[i] <= in_v - trial;
                r_r[i] <= (in_r >> 1) + BITV;
            end else begin
                r_v[i] <= in_v;
                r_r[i] <= in_r >> 1;
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_side  = r_side[N-1];
    assign o_root  = r_r[N-1][vcpc_pkg::ROOT_W-1:0];

endmodule

/* rtl/vcpc_norm.sv */
// Three lane pipelined restoring divider giving round(|d| * 65536 / dist) per axis.
// One quotient bit per register stage. Depends on vcpc_pkg.
module vcpc_norm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  vcpc_pkg::t_side             i_side,
    input  logic [vcpc_pkg::ROOT_W-1:0] i_dist,
    output logic                        o_valid,
    output vcpc_pkg::t_side             o_side,
    output logic [vcpc_pkg::ROOT_W-1:0] o_dist,
    output logic [vcpc_pkg::Q_W-1:0]    o_qx,
    output logic [vcpc_pkg::Q_W-1:0]    o_qy,
    output logic [vcpc_pkg::Q_W-1:0]    o_qz
);

    localparam int N  = vcpc_pkg::DIV_STAGES;
    localparam int L  = vcpc_pkg::LANES;
    localparam int NW = vcpc_pkg::NUM_W;
    localparam int QW = vcpc_pkg::Q_W;
    localparam int DW = vcpc_pkg::ROOT_W;

    logic            r_valid [0:N-1];
    vcpc_pkg::t_side r_side  [0:N-1];
    logic [DW-1:0]   r_dist  [0:N-1];
    logic [NW-1:0]   r_rem   [0:N-1][0:L-1];
    logic [QW-1:0]   r_q     [0:N-1][0:L-1];

    logic [30:0]     mag_in  [0:L-1];

    assign mag_in[0] = i_side.mx;
    assign mag_in[1] = i_side.my;
    assign mag_in[2] = i_side.mz;

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam int K = N - 1 - i;
        logic            in_valid;
        vcpc_pkg::t_side in_side;
        logic [DW-1:0]   in_dist;
        logic [NW-1:0]   den_sh;

        if (i == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_side  = i_side;
            assign in_dist  = i_dist;
        end else begin : g_next
            assign in_valid = r_valid[i-1];
            assign in_side  = r_side[i-1];
            assign in_dist  = r_dist[i-1];
        end

        assign den_sh = NW'({in_dist, 1'b0}) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else begin
                r_valid[i] <= in_valid;
            end
            r_side[i] <= in_side;
            r_dist[i] <= in_dist;
        end

        for (genvar l = 0; l < L; l++) begin : g_lane
            logic [NW-1:0] in_rem;
            logic [QW-1:0] in_q;

            if (i == 0) begin : g_first
                assign in_rem = NW'({mag_in[l], 17'b0}) + NW'(i_dist);
                assign in_q   = '0;
            end else begin : g_next
                assign in_rem = r_rem[i-1][l];
                assign in_q   = r_q[i-1][l];
            end

            always_ff @(posedge i_clk) begin
                if (in_rem >= den_sh) begin
                    r_rem[i][l] <= in_rem - den_sh;
                    r_q[i][l]   <= in_q | (QW'(1) << K);
                end else begin
                    r_rem[i][l] <= in_rem;
                    r_q[i][l]   <= in_q;
                end
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_side  = r_side[N-1];
    assign o_dist  = r_dist[N-1];
    assign o_qx    = r_q[N-1][0];
    assign o_qy    = r_q[N-1][1];
    assign o_qz    = r_q[N-1][2];

endmodule

/* rtl/vertical_capsule_pair_contact_core.sv */
// Vertical capsule pair contact core: one capsule pair per beat, one result beat per pair.
// The pipeline has 4 front stages, 31 square root stages, 17 divider stages and 2 contact
// stages. Throughput is one pair every cycle, busy never rises, and the receiver cannot
// stall. Synchronous active low reset clears all valid bits; no result beat follows reset
// until a new pair is started.
// Depends on vcpc_pkg, vcpc_front, vcpc_sqrt and vcpc_norm.
module vertical_capsule_pair_contact_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_tag_first,
    input  logic [31:0]        i_tag_second,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic [29:0]        i_first_radius,
    input  logic [29:0]        i_first_half_len,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic [29:0]        i_second_radius,
    input  logic [29:0]        i_second_half_len,
    output logic               o_valid,
    output logic               o_hit,
    output logic [31:0]        o_out_tag_first,
    output logic [31:0]        o_out_tag_second,
    output logic signed [31:0] o_contact_x,
    output logic signed [31:0] o_contact_y,
    output logic signed [31:0] o_contact_z,
    output logic signed [17:0] o_normal_x,
    output logic signed [17:0] o_normal_y,
    output logic signed [17:0] o_normal_z,
    output logic [30:0]        o_depth
);

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [16:0] qclamp(input logic [16:0] q);
        return (q > vcpc_pkg::ONE_Q16) ? vcpc_pkg::ONE_Q16 : q;
    endfunction

    function automatic logic signed [17:0] apply_sign(input logic s, input logic [16:0] m);
        return s ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    function automatic logic signed [35:0] offset(input logic signed [17:0] n,
                                                 input logic [46:0] prod);
        logic [46:0] p;
        p = (prod + vcpc_pkg::HALF_LSB) >> 16;
        return n[17] ? -$signed(36'(p)) : $signed(36'(p));
    endfunction

    logic                        f_valid, s_valid, d_valid;
    vcpc_pkg::t_side             f_side, s_side, d_side;
    logic [vcpc_pkg::RAD_W-1:0]  f_rad;
    logic [vcpc_pkg::ROOT_W-1:0] s_root, d_dist;
    logic [vcpc_pkg::Q_W-1:0]    d_qx, d_qy, d_qz;

    logic [16:0]                 n_mx, n_my, n_mz;
    logic                        r_b_valid;
    vcpc_pkg::t_side             r_b_side;
    logic signed [17:0]          r_nx, r_ny, r_nz;
    logic [46:0]                 r_px, r_py, r_pz;
    logic [30:0]                 r_depth;

    assign busy = 1'b0;

    vcpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (start),
        .i_tag_first       (i_tag_first),
        .i_tag_second      (i_tag_second),
        .i_first_x         (i_first_x),
        .i_first_y         (i_first_y),
        .i_first_z         (i_first_z),
        .i_first_radius    (i_first_radius),
        .i_first_half_len  (i_first_half_len),
        .i_second_x        (i_second_x),
        .i_second_y        (i_second_y),
        .i_second_z        (i_second_z),
        .i_second_radius   (i_second_radius),
        .i_second_half_len (i_second_half_len),
        .o_valid           (f_valid),
        .o_side            (f_side),
        .o_rad             (f_rad)
    );

    vcpc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_rad   (f_rad),
        .o_valid (s_valid),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    vcpc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_side  (s_side),
        .i_dist  (s_root),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_dist  (d_dist),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_qz    (d_qz)
    );

    always_comb begin
        n_mx = d_side.near ? 17'd0 : qclamp(d_qx);
        n_my = d_side.near ? vcpc_pkg::ONE_Q16 : qclamp(d_qy);
        n_mz = d_side.near ? 17'd0 : qclamp(d_qz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= d_valid;
        end
        r_b_side <= d_side;
        r_nx     <= apply_sign(d_side.sx, n_mx);
        r_ny     <= apply_sign(d_side.sy && !d_side.near, n_my);
        r_nz     <= apply_sign(d_side.sz, n_mz);
        r_px     <= 47'(n_mx) * 47'(d_side.ra);
        r_py     <= 47'(n_my) * 47'(d_side.ra);
        r_pz     <= 47'(n_mz) * 47'(d_side.ra);
        r_depth  <= (d_dist >= d_side.rs) ? 31'd0 : d_side.rs - d_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_b_valid;
        end
        if (r_b_side.ok) begin
            o_hit            <= 1'b1;
            o_out_tag_first  <= r_b_side.tag_a;
            o_out_tag_second <= r_b_side.tag_b;
            o_contact_x      <= sat32(36'(r_b_side.ax) + offset(r_nx, r_px));
            o_contact_y      <= sat32(36'(r_b_side.ca) + offset(r_ny, r_py));
            o_contact_z      <= sat32(36'(r_b_side.az) + offset(r_nz, r_pz));
            o_normal_x       <= r_nx;
            o_normal_y       <= r_ny;
            o_normal_z       <= r_nz;
            o_depth          <= r_depth;
        end else begin
            o_hit            <= 1'b0;
            o_out_tag_first  <= '0;
            o_out_tag_second <= '0;
            o_contact_x      <= '0;
            o_contact_y      <= '0;
            o_contact_z      <= '0;
            o_normal_x       <= '0;
            o_normal_y       <= '0;
            o_normal_z       <= '0;
            o_depth          <= '0;
        end
    end

endmodule

/* tb/sv/vcpc_contact_checker.sv */
// Checker for the vertical capsule pair contact core: predicts each contact result
// from the accepted pair beats and compares it with every o_valid beat. Depends on nothing.
`timescale 1ns / 100ps
module vcpc_contact_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [31:0]        i_tag_first,
    input  logic [31:0]        i_tag_second,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic [29:0]        i_first_radius,
    input  logic [29:0]        i_first_half_len,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic [29:0]        i_second_radius,
    input  logic [29:0]        i_second_half_len,
    input  logic               o_valid,
    input  logic               o_hit,
    input  logic [31:0]        o_out_tag_first,
    input  logic [31:0]        o_out_tag_second,
    input  logic signed [31:0] o_contact_x,
    input  logic signed [31:0] o_contact_y,
    input  logic signed [31:0] o_contact_z,
    input  logic signed [17:0] o_normal_x,
    input  logic signed [17:0] o_normal_y,
    input  logic signed [17:0] o_normal_z,
    input  logic [30:0]        o_depth,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_hit_count
);
    localparam longint EPS_SQ = 4295;
    localparam longint UNIT = 65536;

    typedef struct {
        logic        hit;
        logic [31:0] tag_a;
        logic [31:0] tag_b;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [17:0] nx;
        logic [17:0] ny;
        logic [17:0] nz;
        logic [30:0] depth;
    } contact_t;

    contact_t contact_q[$];

    function automatic longint clampl(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint absl(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic longint unit_part(longint d, longint root_d);
        longint q;
        q = (absl(d) * 131072 + root_d) / (2 * root_d);
        if (q > UNIT) q = UNIT;
        return (d < 0) ? -q : q;
    endfunction

    function automatic longint scaled(longint n, longint r);
        longint p;
        p = (absl(n) * r + 32768) >>> 16;
        return (n < 0) ? -p : p;
    endfunction

    function automatic contact_t predict_contact();
        contact_t c;
        longint ax, ay, az, bx, by, bz, ra, rb, ha, hb;
        longint a0, a1, b0, b1, ca, cb, dx, dy, dz, rs, root_d, nx, ny, nz, dep;
        longint unsigned dsq;
        bit deg_a, deg_b;
        c = '{default: 0};
        ax = i_first_x; ay = i_first_y; az = i_first_z;
        bx = i_second_x; by = i_second_y; bz = i_second_z;
        ra = i_first_radius; rb = i_second_radius;
        ha = i_first_half_len; hb = i_second_half_len;
        a0 = ay - ha; a1 = ay + ha; b0 = by - hb; b1 = by + hb;
        deg_a = (2 * ha) * (2 * ha) <= EPS_SQ;
        deg_b = (2 * hb) * (2 * hb) <= EPS_SQ;
        if (deg_a && deg_b) begin
            ca = a0; cb = b0;
        end else if (deg_a) begin
            ca = a0; cb = clampl(a0, b0, b1);
        end else if (deg_b || a0 < b0) begin
            ca = clampl(b0, a0, a1); cb = b0;
        end else if (a0 > b1) begin
            ca = a0; cb = b1;
        end else begin
            ca = a0; cb = a0;
        end
        dx = bx - ax; dy = cb - ca; dz = bz - az;
        rs = ra + rb;
        if (absl(dx) >= rs || absl(dy) >= rs || absl(dz) >= rs) return c;
        dsq = dx * dx + dy * dy + dz * dz;
        if (dsq >= rs * rs) return c;
        if (dsq <= EPS_SQ) begin
            root_d = root_floor(EPS_SQ);
            nx = 0; ny = UNIT; nz = 0;
        end else begin
            root_d = root_floor(dsq);
            nx = unit_part(dx, root_d);
            ny = unit_part(dy, root_d);
            nz = unit_part(dz, root_d);
        end
        dep = clampl(rs - root_d, 0, 64'sd2147483647);
        c.hit = 1'b1;
        c.tag_a = i_tag_first;
        c.tag_b = i_tag_second;
        c.cx = 32'(clampl(ax + scaled(nx, ra), -64'sd2147483648, 64'sd2147483647));
        c.cy = 32'(clampl(ca + scaled(ny, ra), -64'sd2147483648, 64'sd2147483647));
        c.cz = 32'(clampl(az + scaled(nz, ra), -64'sd2147483648, 64'sd2147483647));
        c.nx = 18'(nx); c.ny = 18'(ny); c.nz = 18'(nz);
        c.depth = 31'(dep);
        return c;
    endfunction

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_hit_count = 0;
    end

    assign o_pending = contact_q.size();

    always @(posedge i_clk) begin
        contact_t e;
        if (i_rst_n) begin
            if (o_valid) begin
                if (contact_q.size() == 0) begin
                    $error("result beat with no pair outstanding");
                    o_fail_count++;
                end else begin
                    e = contact_q.pop_front();
                    if (e.hit) o_hit_count++;
                    compare_field("hit", e.hit, o_hit);
                    compare_field("out_tag_first", e.tag_a, o_out_tag_first);
                    compare_field("out_tag_second", e.tag_b, o_out_tag_second);
                    compare_field("contact_x", e.cx, $unsigned(o_contact_x));
                    compare_field("contact_y", e.cy, $unsigned(o_contact_y));
                    compare_field("contact_z", e.cz, $unsigned(o_contact_z));
                    compare_field("normal_x", e.nx, $unsigned(o_normal_x));
                    compare_field("normal_y", e.ny, $unsigned(o_normal_y));
                    compare_field("normal_z", e.nz, $unsigned(o_normal_z));
                    compare_field("depth", e.depth, o_depth);
                end
            end
            if (start && !busy) contact_q.push_back(predict_contact());
        end
    end
endmodule

/* tb/sv/tb_vertical_capsule_pair_contact_core.sv */
// Top of the contact core testbench: clock, reset, directed and random pair beats, verdict.
// Depends on vertical_capsule_pair_contact_core and vcpc_contact_checker.
`timescale 1ns / 100ps
module tb_vertical_capsule_pair_contact_core;
    localparam int LATENCY = 54;
    localparam int RANDOM_PAIRS = 1500;
    localparam longint CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        tag_a, tag_b;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [29:0]        ra, ha, rb, hb;
    logic               o_valid, o_hit;
    logic [31:0]        o_tag_a, o_tag_b;
    logic signed [31:0] o_cx, o_cy, o_cz;
    logic signed [17:0] o_nx, o_ny, o_nz;
    logic [30:0]        o_depth;
    int                 fail_count, pending, hit_count;
    longint             cycles;

    vertical_capsule_pair_contact_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_tag_first(tag_a), .i_tag_second(tag_b),
        .i_first_x(ax), .i_first_y(ay), .i_first_z(az),
        .i_first_radius(ra), .i_first_half_len(ha),
        .i_second_x(bx), .i_second_y(by), .i_second_z(bz),
        .i_second_radius(rb), .i_second_half_len(hb),
        .o_valid(o_valid), .o_hit(o_hit),
        .o_out_tag_first(o_tag_a), .o_out_tag_second(o_tag_b),
        .o_contact_x(o_cx), .o_contact_y(o_cy), .o_contact_z(o_cz),
        .o_normal_x(o_nx), .o_normal_y(o_ny), .o_normal_z(o_nz), .o_depth(o_depth)
    );

    vcpc_contact_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_tag_first(tag_a), .i_tag_second(tag_b),
        .i_first_x(ax), .i_first_y(ay), .i_first_z(az),
        .i_first_radius(ra), .i_first_half_len(ha),
        .i_second_x(bx), .i_second_y(by), .i_second_z(bz),
        .i_second_radius(rb), .i_second_half_len(hb),
        .o_valid(o_valid), .o_hit(o_hit),
        .o_out_tag_first(o_tag_a), .o_out_tag_second(o_tag_b),
        .o_contact_x(o_cx), .o_contact_y(o_cy), .o_contact_z(o_cz),
        .o_normal_x(o_nx), .o_normal_y(o_ny), .o_normal_z(o_nz), .o_depth(o_depth),
        .o_fail_count(fail_count), .o_pending(pending), .o_hit_count(hit_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4));
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Drives the pair at the falling edge and holds it until the core accepts it.
    task automatic send_pair(logic [31:0] t0, logic [31:0] t1,
                             logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                             logic [29:0] r0, logic [29:0] h0,
                             logic [31:0] x1, logic [31:0] y1, logic [31:0] z1,
                             logic [29:0] r1, logic [29:0] h1);
        tag_a <= t0; tag_b <= t1;
        ax <= x0; ay <= y0; az <= z0; ra <= r0; ha <= h0;
        bx <= x1; by <= y1; bz <= z1; rb <= r1; hb <= h1;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] base, int spread);
        return base + 32'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic random_pair();
        logic [31:0] x0, y0, z0;
        logic [29:0] r0, r1, h0, h1;
        int spread, kind;
        kind = $urandom_range(0, 9);
        x0 = $urandom; y0 = $urandom; z0 = $urandom;
        if (kind == 0) begin
            send_pair($urandom, $urandom, x0, y0, z0, 30'($urandom), 30'($urandom),
                      $urandom, $urandom, $urandom, 30'($urandom), 30'($urandom));
        end else begin
            spread = (kind < 4) ? 1 << 20 : ((kind < 7) ? 1 << 17 : 64);
            r0 = 30'($urandom_range(0, 2 * spread));
            r1 = 30'($urandom_range(0, 2 * spread));
            h0 = ($urandom_range(0, 3) == 0) ? 30'($urandom_range(0, 40))
                                             : 30'($urandom_range(0, 2 * spread));
            h1 = ($urandom_range(0, 3) == 0) ? 30'($urandom_range(0, 40))
                                             : 30'($urandom_range(0, 2 * spread));
            if (kind == 9) begin
                r0 = 30'($urandom_range(30'h3FF00000, 30'h3FFFFFFF));
                r1 = 30'($urandom_range(30'h3FF00000, 30'h3FFFFFFF));
                h0 = 30'($urandom);
            end
            send_pair($urandom, $urandom, x0, y0, z0, r0, h0,
                      near_coord(x0, spread), near_coord(y0, 3 * spread),
                      near_coord(z0, spread), r1, h1);
        end
    endtask

    initial begin
        cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        {tag_a, tag_b, ax, ay, az, bx, by, bz} = '0;
        {ra, ha, rb, hb} = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Coincident spheres, exact overlap, near-zero distance and a zero radius sum.
        send_pair(32'h1, 32'h2, 0, 0, 0, 30'h10000, 0, 0, 0, 0, 30'h10000, 0);
        send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(3, 4, 0, 0, 0, 30'h10000, 0, 32'h20, 0, 32'h10, 30'h10000, 0);
        send_pair(5, 6, 0, 0, 0, 30'h10000, 0, 32'h20000, 0, 0, 30'h10000, 0);
        send_pair(7, 8, 0, 0, 0, 30'h10000, 0, 32'h1FFFF, 0, 0, 30'h10000, 0);
        // Segment ordering cases: below, above, overlapping, one degenerate.
        send_pair(9, 10, 0, 0, 0, 30'h8000, 30'h10000, 32'h4000, 32'h40000, 0,
                  30'h8000, 30'h10000);
        send_pair(11, 12, 0, 32'h40000, 0, 30'h8000, 30'h10000, 0, 0, 32'h4000,
                  30'h8000, 30'h10000);
        send_pair(13, 14, 0, 0, 0, 30'h8000, 30'h20000, 32'h4000, 32'h8000, 0,
                  30'h8000, 30'h10000);
        send_pair(15, 16, 0, 0, 0, 30'h8000, 32, 32'hFFFFC000, 32'h8000, 0,
                  30'h8000, 30'h10000);
        send_pair(17, 18, 0, 32'h8000, 0, 30'h8000, 30'h10000, 0, 0, 32'hFFFFC000,
                  30'h8000, 33);
        // Full-range extremes and saturation of the contact point.
        send_pair(19, 20, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 30'h3FFFFFFF,
                  30'h3FFFFFFF, 32'h7FFF0000, 32'h7FFFFFFF, 32'h7FFFFFFF, 30'h3FFFFFFF,
                  30'h3FFFFFFF);
        send_pair(21, 22, 32'h80000000, 32'h80000000, 32'h80000000, 30'h3FFFFFFF,
                  30'h3FFFFFFF, 32'h80010000, 32'h80000000, 32'h80000000, 30'h3FFFFFFF,
                  30'h3FFFFFFF);
        send_pair(23, 24, 32'h80000000, 0, 0, 30'h3FFFFFFF, 0, 32'h7FFFFFFF, 0, 0,
                  30'h3FFFFFFF, 0);
        send_pair(25, 26, 0, 32'h7FFFFFFF, 0, 30'h3FFFFFFF, 30'h3FFFFFFF, 0,
                  32'h80000000, 0, 30'h3FFFFFFF, 30'h3FFFFFFF);

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            random_pair();
            idle_gap();
            if (i == RANDOM_PAIRS / 2) begin
                start <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Ran %0d directed and %0d random capsule pairs, %0d of them in contact.",
                 14, RANDOM_PAIRS, hit_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
